// File: src/bawt_pkg.sv
`default_nettype none

package bawt_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned WIDTH_W  = 2;
    localparam int unsigned CYCLES_W = 6;
    localparam int unsigned PAGE_W   = 20;
    localparam int unsigned SIZE_W   = 5;
    localparam int unsigned CTRL_W   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = PAGE_W;
    localparam int unsigned ROW_W    = 4;
    localparam int unsigned COL_W    = 3;
    localparam int unsigned PAGE_SHIFT = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ITCM_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITCM_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DTCM_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DTCM_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TCM_CTRL  = 3'd4;

    localparam logic [PAGE_W-1:0] DTCM_BASE_RESET = 20'd10176;

    localparam logic [WIDTH_W-1:0] WIDTH_BYTE  = 2'd0;
    localparam logic [WIDTH_W-1:0] WIDTH_HALF  = 2'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_WORD  = 2'd2;
    localparam logic [WIDTH_W-1:0] WIDTH_BAD   = 2'd3;

    localparam int unsigned CTRL_DTCM_EN = 0;
    localparam int unsigned CTRL_DTCM_LD = 1;
    localparam int unsigned CTRL_ITCM_EN = 2;
    localparam int unsigned CTRL_ITCM_LD = 3;

    localparam logic [SIZE_W-1:0] SIZE_MIN = 5'd3;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 5'd23;
    localparam logic [ADDR_W:0]   WINDOW_UNIT = 33'd512;

    localparam logic [CYCLES_W-1:0] TCM_CYCLES = 6'd1;

    typedef logic [0:8][0:7][CYCLES_W-1:0] timing_table_t;

    // columns: code ns32, s32, ns16, s16, data ns32, s32, ns16, s16
    localparam timing_table_t TIMING_ROWS = '{
        '{6'd18, 6'd18, 6'd9,  6'd9,  6'd20, 6'd4,  6'd18, 6'd2 },
        '{6'd8,  6'd8,  6'd4,  6'd4,  6'd8,  6'd2,  6'd8,  6'd2 },
        '{6'd8,  6'd8,  6'd4,  6'd4,  6'd8,  6'd2,  6'd8,  6'd2 },
        '{6'd10, 6'd10, 6'd5,  6'd5,  6'd10, 6'd4,  6'd8,  6'd2 },
        '{6'd10, 6'd10, 6'd5,  6'd5,  6'd10, 6'd4,  6'd8,  6'd2 },
        '{6'd8,  6'd8,  6'd4,  6'd4,  6'd8,  6'd2,  6'd8,  6'd2 },
        '{6'd38, 6'd38, 6'd19, 6'd19, 6'd38, 6'd24, 6'd26, 6'd12},
        '{6'd0,  6'd0,  6'd0,  6'd0,  6'd26, 6'd20, 6'd26, 6'd20},
        '{6'd8,  6'd8,  6'd4,  6'd4,  6'd8,  6'd2,  6'd8,  6'd2 }
    };

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
    } region_t;

    function automatic region_t region_decode(input logic [7:0] top);
        region_t r;
        r.hit = 1'b1;
        r.row = '0;
        unique case (top)
            8'h02: r.row = 4'd0;
            8'h03: r.row = 4'd1;
            8'h04: r.row = 4'd2;
            8'h05: r.row = 4'd3;
            8'h06: r.row = 4'd4;
            8'h07: r.row = 4'd5;
            8'h08: r.row = 4'd6;
            8'h09: r.row = 4'd6;
            8'h0A: r.row = 4'd7;
            8'hFF: r.row = 4'd8;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic window_hit(
        input logic [ADDR_W-1:0] addr,
        input logic [PAGE_W-1:0] page,
        input logic [SIZE_W-1:0] code
    );
        logic [SIZE_W-1:0] clamped;
        logic [ADDR_W:0]   base;
        logic [ADDR_W:0]   limit;
        logic [ADDR_W:0]   a;
        clamped = code;
        if (code < SIZE_MIN)
        begin
            clamped = SIZE_MIN;
        end
        else if (code > SIZE_MAX)
        begin
            clamped = SIZE_MAX;
        end
        base  = {1'b0, page, {PAGE_SHIFT{1'b0}}};
        limit = base + (WINDOW_UNIT << clamped);
        a     = {1'b0, addr};
        return (code != '0) && (a >= base) && (a < limit);
    endfunction

endpackage

`default_nettype wire

// File: src/bawt_acc_if.sv
`default_nettype none

interface bawt_acc_if;
    import bawt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   address;
    logic [WIDTH_W-1:0]  width_code;
    logic                is_write;
    logic                is_code;

    modport source (output valid, address, width_code, is_write, is_code, input ready);
    modport sink   (input valid, address, width_code, is_write, is_code, output ready);
endinterface

`default_nettype wire

// File: src/bawt_res_if.sv
`default_nettype none

interface bawt_res_if;
    import bawt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CYCLES_W-1:0] wait_cycles;
    logic                sequential;
    logic                error;

    modport source (output valid, wait_cycles, sequential, error, input ready);
    modport sink   (input valid, wait_cycles, sequential, error, output ready);
endinterface

`default_nettype wire

// File: src/bawt_cfg_if.sv
`default_nettype none

interface bawt_cfg_if;
    import bawt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/bus_access_wait_timing.sv
// Bus access wait-cycle timing.
// acc: one beat per bus access (address, width_code, is_write, is_code).
// res: one beat per access (wait_cycles, sequential, error), in order.
// cfg: register writes (index, data); always ready, write only while idle.
//   0 ITCM base page, 1 ITCM size code, 2 DTCM base page,
//   3 DTCM size code, 4 TCM control.
// A beat taken on acc passes through the input register and then the
// result register to res. Throughput: one access per cycle unless res
// stalls; the last-address registers update as an access moves into the
// result register, so the next access sees them. When res stalls, the
// result register holds, the input register fills, and acc.ready drops;
// it rises again in the cycle res takes a beat.
// Reset clears both pipeline stages and the last code and data addresses
// and loads the register reset values (DTCM base page 10176, rest zero).
// An unsupported width returns error with zero cycles and leaves the last
// addresses untouched.
`default_nettype none

module bus_access_wait_timing
    import bawt_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    bawt_acc_if.sink    acc,
    bawt_res_if.source  res,
    bawt_cfg_if.sink    cfg
);

    logic [PAGE_W-1:0] itcm_base_reg;
    logic [SIZE_W-1:0] itcm_span_reg;
    logic [PAGE_W-1:0] dtcm_base_reg;
    logic [SIZE_W-1:0] dtcm_span_reg;
    logic [CTRL_W-1:0] tcm_ctrl_reg;

    logic [ADDR_W-1:0] last_code_reg;
    logic [ADDR_W-1:0] last_data_reg;

    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [WIDTH_W-1:0] s1_width_reg;
    logic               s1_write_reg;
    logic               s1_code_reg;

    logic                out_valid_reg;
    logic [CYCLES_W-1:0] out_cycles_reg;
    logic                out_seq_reg;
    logic                out_err_reg;

    logic                s1_advance;
    logic                code_fetch;
    logic                bad_width;
    logic [ADDR_W-1:0]   prev_addr;
    logic                seq;
    logic                itcm_hit;
    logic                dtcm_hit;
    region_t             region;
    logic [COL_W-1:0]    col;
    logic [CYCLES_W-1:0] cycles_next;
    logic                seq_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itcm_base_reg <= '0;
            itcm_span_reg <= '0;
            dtcm_base_reg <= DTCM_BASE_RESET;
            dtcm_span_reg <= '0;
            tcm_ctrl_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ITCM_BASE: itcm_base_reg <= cfg.data;
                REG_ITCM_SIZE: itcm_span_reg <= cfg.data[SIZE_W-1:0];
                REG_DTCM_BASE: dtcm_base_reg <= cfg.data;
                REG_DTCM_SIZE: dtcm_span_reg <= cfg.data[SIZE_W-1:0];
                REG_TCM_CTRL:  tcm_ctrl_reg  <= cfg.data[CTRL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_advance = !out_valid_reg || res.ready;
    assign acc.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (acc.ready)
        begin
            s1_valid_reg <= acc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.ready && acc.valid)
        begin
            s1_addr_reg  <= acc.address;
            s1_width_reg <= acc.width_code;
            s1_write_reg <= acc.is_write;
            s1_code_reg  <= acc.is_code;
        end
    end

    assign code_fetch = !s1_write_reg && s1_code_reg;
    assign bad_width  = (s1_width_reg == WIDTH_BAD);
    assign prev_addr  = code_fetch ? last_code_reg : last_data_reg;
    assign seq        = (s1_addr_reg == prev_addr + 32'd4)
                     || (s1_addr_reg == prev_addr + 32'd2);

    assign itcm_hit = tcm_ctrl_reg[CTRL_ITCM_EN]
                   && (s1_write_reg || !tcm_ctrl_reg[CTRL_ITCM_LD])
                   && window_hit(s1_addr_reg, itcm_base_reg, itcm_span_reg);
    assign dtcm_hit = tcm_ctrl_reg[CTRL_DTCM_EN]
                   && (s1_write_reg || !tcm_ctrl_reg[CTRL_DTCM_LD])
                   && window_hit(s1_addr_reg, dtcm_base_reg, dtcm_span_reg);

    assign region = region_decode(s1_addr_reg[ADDR_W-1 -: 8]);
    assign col    = {!code_fetch || (s1_width_reg == WIDTH_BYTE),
                     s1_width_reg != WIDTH_WORD,
                     seq};

    always_comb
    begin
        priority if (bad_width)
        begin
            cycles_next = '0;
        end
        else if (itcm_hit || dtcm_hit)
        begin
            cycles_next = TCM_CYCLES;
        end
        else if (region.hit)
        begin
            cycles_next = TIMING_ROWS[region.row][col];
        end
        else
        begin
            cycles_next = '0;
        end
    end

    assign seq_next = seq && !bad_width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg <= '0;
            last_data_reg <= '0;
        end
        else if (s1_valid_reg && s1_advance && !bad_width)
        begin
            if (code_fetch)
            begin
                last_code_reg <= s1_addr_reg;
            end
            else
            begin
                last_data_reg <= s1_addr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_cycles_reg <= cycles_next;
            out_seq_reg    <= seq_next;
            out_err_reg    <= bad_width;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.wait_cycles = out_cycles_reg;
    assign res.sequential  = out_seq_reg;
    assign res.error       = out_err_reg;

endmodule

`default_nettype wire

// File: tb/bus_access_wait_timing_tb.sv
`default_nettype none

module bus_access_wait_timing_tb
    import bawt_pkg::*;
();

    localparam int unsigned STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_TCM_CTRL + 1'b1;

    typedef struct packed {
        logic [CYCLES_W-1:0] wait_cycles;
        logic                sequential;
        logic                error;
    } timing_t;

    logic clk;
    logic rst_n;

    bawt_acc_if acc_if ();
    bawt_res_if res_if ();
    bawt_cfg_if cfg_if ();

    bus_access_wait_timing DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // shadow registers and last-address state
    logic [PAGE_W-1:0] itcm_page;
    logic [SIZE_W-1:0] itcm_span;
    logic [PAGE_W-1:0] dtcm_page;
    logic [SIZE_W-1:0] dtcm_span;
    logic [CTRL_W-1:0] tcm_ctrl;
    logic [ADDR_W-1:0] last_code_addr;
    logic [ADDR_W-1:0] last_data_addr;

    timing_t     pending_timings[$];
    timing_t     oldest_timing;
    int          error_count;
    int          idle_pct;
    int unsigned stall_count;

    always #10 clk = ~clk;

    function automatic logic [ADDR_W:0] window_end(input logic [PAGE_W-1:0] page,
                                                    input logic [SIZE_W-1:0] code);
        logic [SIZE_W-1:0] c;
        c = (code < 5'd3) ? 5'd3 : (code > 5'd23) ? 5'd23 : code;
        return {1'b0, page, 12'h000} + (33'd512 << c);
    endfunction

    function automatic logic tcm_hit(input logic [ADDR_W-1:0] addr,
                                     input logic [PAGE_W-1:0] page,
                                     input logic [SIZE_W-1:0] code);
        logic [ADDR_W:0] lo;
        lo = {1'b0, page, 12'h000};
        return (code != '0) && ({1'b0, addr} >= lo) && ({1'b0, addr} < window_end(page, code));
    endfunction

    function automatic logic [CYCLES_W-1:0] table_cycles(input logic [7:0] top, input int col);
        logic [0:7][CYCLES_W-1:0] r;
        case (top)
            8'h02: r = {6'd18, 6'd18, 6'd9, 6'd9, 6'd20, 6'd4, 6'd18, 6'd2};
            8'h03, 8'h04, 8'h07, 8'hFF:
                r = {6'd8, 6'd8, 6'd4, 6'd4, 6'd8, 6'd2, 6'd8, 6'd2};
            8'h05, 8'h06:
                r = {6'd10, 6'd10, 6'd5, 6'd5, 6'd10, 6'd4, 6'd8, 6'd2};
            8'h08, 8'h09:
                r = {6'd38, 6'd38, 6'd19, 6'd19, 6'd38, 6'd24, 6'd26, 6'd12};
            8'h0A: r = {6'd0, 6'd0, 6'd0, 6'd0, 6'd26, 6'd20, 6'd26, 6'd20};
            default: r = '0;
        endcase
        return r[col];
    endfunction

    task automatic predict_timing(input logic [ADDR_W-1:0] addr, input logic [WIDTH_W-1:0] width,
                                  input logic wr, input logic code);
        logic              fetch;
        logic [ADDR_W-1:0] prev;
        logic              tcm;
        int                col;
        timing_t           t;
        fetch = !wr && code;
        prev  = fetch ? last_code_addr : last_data_addr;
        if (width == WIDTH_BAD)
        begin
            t.wait_cycles = '0;
            t.sequential  = 1'b0;
            t.error       = 1'b1;
            pending_timings.push_back(t);
            return;
        end
        t.error      = 1'b0;
        t.sequential = (addr == prev + 32'd4) || (addr == prev + 32'd2);
        tcm = (tcm_ctrl[CTRL_ITCM_EN] && (wr || !tcm_ctrl[CTRL_ITCM_LD])
               && tcm_hit(addr, itcm_page, itcm_span))
           || (tcm_ctrl[CTRL_DTCM_EN] && (wr || !tcm_ctrl[CTRL_DTCM_LD])
               && tcm_hit(addr, dtcm_page, dtcm_span));
        if (tcm)
        begin
            t.wait_cycles = 6'd1;
        end
        else
        begin
            col = ((width == WIDTH_WORD) ? 0 : 2) + (t.sequential ? 1 : 0);
            if (!fetch || width == WIDTH_BYTE)
            begin
                col = col + 4;
            end
            t.wait_cycles = table_cycles(addr[31:24], col);
        end
        if (fetch)
        begin
            last_code_addr = addr;
        end
        else
        begin
            last_data_addr = addr;
        end
        pending_timings.push_back(t);
    endtask

    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [WIDTH_W-1:0] width,
                               input logic wr, input logic code);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            acc_if.valid <= 1'b0;
            @(posedge clk);
        end
        acc_if.valid      <= 1'b1;
        acc_if.address    <= addr;
        acc_if.width_code <= width;
        acc_if.is_write   <= wr;
        acc_if.is_code    <= code;
        do @(posedge clk); while (!acc_if.ready);
        predict_timing(addr, width, wr, code);
    endtask

    task automatic wait_idle();
        acc_if.valid <= 1'b0;
        while (pending_timings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_ITCM_BASE: itcm_page = data;
            REG_ITCM_SIZE: itcm_span = data[SIZE_W-1:0];
            REG_DTCM_BASE: dtcm_page = data;
            REG_DTCM_SIZE: dtcm_span = data[SIZE_W-1:0];
            REG_TCM_CTRL:  tcm_ctrl  = data[CTRL_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits of the narrow registers are random to exercise masking
    task automatic set_tcm(input logic [PAGE_W-1:0] ipage, input logic [SIZE_W-1:0] isize,
                           input logic [PAGE_W-1:0] dpage, input logic [SIZE_W-1:0] dsize,
                           input logic [CTRL_W-1:0] ctrl);
        logic [CFG_DATA_W-1:0] r;
        wait_idle();
        r = CFG_DATA_W'($urandom);
        write_reg(REG_ITCM_BASE, ipage);
        write_reg(REG_ITCM_SIZE, {r[CFG_DATA_W-1:SIZE_W], isize});
        write_reg(REG_DTCM_BASE, dpage);
        r = CFG_DATA_W'($urandom);
        write_reg(REG_DTCM_SIZE, {r[CFG_DATA_W-1:SIZE_W], dsize});
        r = CFG_DATA_W'($urandom);
        write_reg(REG_TCM_CTRL, {r[CFG_DATA_W-1:CTRL_W], ctrl});
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [WIDTH_W-1:0] pick_width();
        int unsigned p;
        p = $urandom_range(0, 24);
        if (p == 0)
        begin
            return WIDTH_BAD;
        end
        return (p < 9) ? WIDTH_BYTE : (p < 17) ? WIDTH_HALF : WIDTH_WORD;
    endfunction

    function automatic logic [7:0] pick_top();
        case ($urandom_range(0, 11))
            0:  return 8'h02;
            1:  return 8'h03;
            2:  return 8'h04;
            3:  return 8'h05;
            4:  return 8'h06;
            5:  return 8'h07;
            6:  return 8'h08;
            7:  return 8'h09;
            8:  return 8'h0A;
            9:  return 8'hFF;
            10: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        logic [PAGE_W-1:0] r;
        r = PAGE_W'($urandom);
        case ($urandom_range(0, 3))
            0: return r;
            1: return {pick_top(), r[11:0]};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] prev);
        logic [ADDR_W-1:0] r;
        logic [ADDR_W:0]   b;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return prev + ($urandom_range(0, 1) ? 32'd4 : 32'd2);
            4, 5, 6:    return {pick_top(), r[23:0]};
            7:
            begin
                if ($urandom_range(0, 1))
                begin
                    b = $urandom_range(0, 1) ? {1'b0, itcm_page, 12'h000}
                                             : window_end(itcm_page, itcm_span);
                end
                else
                begin
                    b = $urandom_range(0, 1) ? {1'b0, dtcm_page, 12'h000}
                                             : window_end(dtcm_page, dtcm_span);
                end
                return b[ADDR_W-1:0] + $urandom_range(0, 8) - 32'd4;
            end
            8:       return r;
            default: return prev + $urandom_range(0, 16) - 32'd8;
        endcase
    endfunction

    task automatic send_random_access();
        logic              wr;
        logic              code;
        logic [ADDR_W-1:0] prev;
        wr   = 1'($urandom_range(0, 1));
        code = 1'($urandom_range(0, 1));
        prev = (!wr && code) ? last_code_addr : last_data_addr;
        send_access(pick_address(prev), pick_width(), wr, code);
    endtask

    task automatic test_directed();
        send_access(32'h0000_0004, WIDTH_WORD, 1'b0, 1'b0);
        send_access(32'h0200_0000, WIDTH_WORD, 1'b0, 1'b1);
        send_access(32'h0200_0004, WIDTH_WORD, 1'b0, 1'b1);
        send_access(32'h0200_0006, WIDTH_HALF, 1'b0, 1'b1);
        send_access(32'h0200_0008, WIDTH_BYTE, 1'b0, 1'b1);
        send_access(32'h0200_0100, WIDTH_WORD, 1'b1, 1'b1);
        send_access(32'h0200_0104, WIDTH_WORD, 1'b1, 1'b0);
        send_access(32'h0300_0000, WIDTH_HALF, 1'b0, 1'b0);
        send_access(32'h0400_0000, WIDTH_WORD, 1'b0, 1'b0);
        send_access(32'h0500_0000, WIDTH_HALF, 1'b0, 1'b1);
        send_access(32'h0600_0002, WIDTH_BYTE, 1'b1, 1'b0);
        send_access(32'h07FF_FFFC, WIDTH_WORD, 1'b0, 1'b1);
        send_access(32'h0800_0000, WIDTH_WORD, 1'b0, 1'b1);
        send_access(32'h09FF_FFFC, WIDTH_WORD, 1'b0, 1'b0);
        send_access(32'h0A00_0000, WIDTH_WORD, 1'b0, 1'b1);
        send_access(32'h0A00_0002, WIDTH_HALF, 1'b1, 1'b0);
        send_access(32'hFF00_0000, WIDTH_WORD, 1'b0, 1'b1);
        send_access(32'hFFFF_FFFE, WIDTH_HALF, 1'b0, 1'b0);
        send_access(32'h0000_0000, WIDTH_HALF, 1'b0, 1'b0);
        send_access(32'h0000_0004, WIDTH_BAD, 1'b1, 1'b0);
        send_access(32'h0000_0002, WIDTH_BAD, 1'b0, 1'b1);
        send_access(32'h0000_0002, WIDTH_HALF, 1'b1, 1'b0);
        send_access(32'h0B00_0000, WIDTH_WORD, 1'b0, 1'b0);
        send_access(32'hFFFF_FFFF, WIDTH_BYTE, 1'b1, 1'b1);
    endtask

    task automatic probe_windows();
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        logic [ADDR_W:0] a;
        for (int k = 0; k < 8; k++)
        begin
            lo = (k < 4) ? {1'b0, itcm_page, 12'h000} : {1'b0, dtcm_page, 12'h000};
            hi = (k < 4) ? window_end(itcm_page, itcm_span) : window_end(dtcm_page, dtcm_span);
            case (k % 4)
                0:       a = lo - 1'b1;
                1:       a = lo;
                2:       a = hi - 1'b1;
                default: a = hi;
            endcase
            send_access(a[ADDR_W-1:0], pick_width(), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_tcm_windows();
        set_tcm(20'h00000, 5'd23, 20'hFFFFF, 5'd1, 4'b0111);
        probe_windows();
        set_tcm(20'h02000, 5'd24, 20'h027C0, 5'd5, 4'b1101);
        probe_windows();
        set_tcm(20'hFFFFF, 5'd31, 20'h00000, 5'd0, 4'b1111);
        probe_windows();
        set_tcm(20'h12345, 5'd2, DTCM_BASE_RESET, 5'd3, 4'b0101);
        probe_windows();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++)
        begin
            set_tcm(pick_page(), SIZE_W'($urandom_range(0, 31)), pick_page(),
                    SIZE_W'($urandom_range(0, 31)), CTRL_W'($urandom_range(0, 15)));
            repeat (250) send_random_access();
        end
    endtask

    task automatic test_no_idle();
        set_tcm(pick_page(), SIZE_W'($urandom_range(0, 31)), pick_page(),
                SIZE_W'($urandom_range(0, 31)), CTRL_W'($urandom_range(0, 15)));
        idle_pct = 0;
        repeat (300) send_random_access();
        wait_idle();
        idle_pct = 27;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_timings.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                oldest_timing = pending_timings.pop_front();
                if (res_if.wait_cycles !== oldest_timing.wait_cycles)
                begin
                    $error("wait_cycles: expected %0d, got %0d",
                           oldest_timing.wait_cycles, res_if.wait_cycles);
                    error_count++;
                end
                if (res_if.sequential !== oldest_timing.sequential)
                begin
                    $error("sequential: expected %0b, got %0b",
                           oldest_timing.sequential, res_if.sequential);
                    error_count++;
                end
                if (res_if.error !== oldest_timing.error)
                begin
                    $error("error: expected %0b, got %0b", oldest_timing.error, res_if.error);
                    error_count++;
                end
            end
        end
        res_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            begin
                stall_count <= 0;
            end
            else if (stall_count >= STALL_LIMIT)
            begin
                $display("bus_access_wait_timing_tb: FAIL");
                $finish;
            end
            else
            begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        acc_if.valid      = 1'b0;
        acc_if.address    = '0;
        acc_if.width_code = WIDTH_BYTE;
        acc_if.is_write   = 1'b0;
        acc_if.is_code    = 1'b0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_ITCM_BASE;
        cfg_if.data       = '0;
        itcm_page         = '0;
        itcm_span         = '0;
        dtcm_page         = DTCM_BASE_RESET;
        dtcm_span         = '0;
        tcm_ctrl          = '0;
        last_code_addr    = '0;
        last_data_addr    = '0;
        error_count       = 0;
        stall_count       = 0;
        idle_pct          = 27;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_tcm_windows();
        test_random();
        test_no_idle();

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_timings.size() == 0)
        begin
            $display("bus_access_wait_timing_tb: PASS");
        end
        else
        begin
            $display("bus_access_wait_timing_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/bawt_pkg.sv
src/bawt_acc_if.sv
src/bawt_res_if.sv
src/bawt_cfg_if.sv
src/bus_access_wait_timing.sv
tb/bus_access_wait_timing_tb.sv
